@@ design/nfss_pkg.sv @@
// Shared constants, types and tables of the noise-floor spectral subtraction block
`timescale 1ns / 1ps
package nfss_pkg;

  // fixed-point constants
  localparam int EXP_STEPS = 24;
  localparam int LOG_BITS  = 20;
  localparam logic signed [23:0] K_EXP = 24'sd5573271;
  localparam logic signed [18:0] K_DB  = 19'sd197283;
  localparam logic [63:0] POWER_MIN = 64'd110;
  localparam logic signed [15:0] MAG_MIN = -16'sd30720;
  localparam logic signed [15:0] MAG_MAX = 16'sd10240;
  localparam logic signed [15:0] DB_OF_ZERO = 16'sh8000;
  localparam logic [8:0] FRAMES_MAX = 9'h1FF;
  localparam logic [10:0] POS_MAX = 11'h7FF;

  // item operations
  typedef enum logic [1:0] {
    FUNC_EST = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_CLR = 2'd2,
    FUNC_NOP = 2'd3
  } func_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_BINS   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFLOOR = 4'd3;

  // roots of two, Q2.30, each the square root of the one before
  typedef logic [31:0] root_tab_t [0:EXP_STEPS];

  function automatic logic [63:0] isqrt64(logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic root_tab_t build_roots();
    root_tab_t tab;
    tab[0] = 32'h8000_0000;
    tab[1] = 32'(isqrt64(64'd1 << 61));
    for (int k = 2; k <= EXP_STEPS; k++) begin
      tab[k] = 32'(isqrt64(64'(tab[k-1]) << 30));
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic clr_state;
    logic clr_wr;
    logic idx_clr;
    logic idx_inc;
    logic mem_idx;
    logic exp_start;
    logic exp_src;
    logic ps_keep;
    logic sum_wr;
    logic frame_inc;
    logic div_start;
    logic log_start;
    logic log_src;
    logic floor_wr;
    logic set_ready;
    logic clean_log;
    logic clean_ofl;
    logic emit;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    func_t func;
    logic  ready_flag;
    logic  in_range;
    logic  idx_last_clr;
    logic  idx_last_walk;
    logic  frames_hit;
    logic  fe;
    logic  exp_done;
    logic  log_done;
    logic  div_done;
    logic  out_free;
  } dp_stat_t;

endpackage

@@ design/nfss_bin_if.sv @@
// Input request channel carrying one spectrum bin
`timescale 1ns / 1ps
interface nfss_bin_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic signed [15:0] mag_db;
  logic              frame_end;

  modport source (output valid, func, mag_db, frame_end, input ready);
  modport sink (input valid, func, mag_db, frame_end, output ready);
endinterface

@@ design/nfss_result_if.sv @@
// Output request channel carrying one result
`timescale 1ns / 1ps
interface nfss_result_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] clean_db;
  logic              estimate_done;
  logic              floor_ready;
  logic              frame_last;

  modport source (output valid, clean_db, estimate_done, floor_ready, frame_last, input ready);
  modport sink (input valid, clean_db, estimate_done, floor_ready, frame_last, output ready);
endinterface

@@ design/nfss_cfg_if.sv @@
// Configuration write channel
`timescale 1ns / 1ps
interface nfss_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/noise_floor_spectral_subtract_core.sv @@
// Top level of the noise-floor spectral subtraction block
`timescale 1ns / 1ps
// Usage:
//   bin    : one spectrum bin per request (func, mag_db in Q8.8 dB, frame_end).
//   result : one result per request (clean_db, estimate_done, floor_ready,
//            frame_last), held in an output register until taken.
//   cfg    : register writes (index, data), always ready; write only while idle.
// Estimate requests add the power of each bin in use to a per-bin sum until
// the floor is fixed; the request that ends the configured number of frames
// walks every bin in use, divides its sum and stores the mean level in dB.
// Subtract requests remove floor plus margin in linear power. Clear requests
// zero both stores. A subtract of a bin in use runs two 24-step power
// conversions and one log conversion; the frame-completing estimate runs the
// bit-serial divider and the log unit for each bin in use. A clear request
// clears every store row, one row per cycle. One request is in work at a
// time; the next is taken once the previous result sits in the output
// register. After reset a clearing pass over every store row runs with
// bin.ready low. A stalled receiver holds the result and the block waits
// before loading the next.
module noise_floor_spectral_subtract_core #(
  parameter int MAX_BINS  = 1024,
  parameter int SUM_WIDTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  nfss_bin_if.sink      bin,
  nfss_result_if.source result,
  nfss_cfg_if.sink      cfg
);
  import nfss_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg.ready = 1'b1;

  nfss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (bin.valid),
    .req_ready (bin.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  nfss_dp #(
    .MAX_BINS  (MAX_BINS),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .in_func           (bin.func),
    .in_mag_db         (bin.mag_db),
    .in_frame_end      (bin.frame_end),
    .cfg_we            (cfg.valid),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .out_ready         (result.ready),
    .out_valid         (result.valid),
    .out_clean_db      (result.clean_db),
    .out_estimate_done (result.estimate_done),
    .out_floor_ready   (result.floor_ready),
    .out_frame_last    (result.frame_last)
  );

endmodule

@@ design/nfss_exp.sv @@
// dB to linear power unit: one root-of-two multiply per cycle
`timescale 1ns / 1ps
module nfss_exp (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [17:0] x,
  output logic               done,
  output logic [63:0]        res
);
  import nfss_pkg::*;

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_STEP = 3'b010,
    E_FIN  = 3'b100
  } exp_state_t;

  exp_state_t state;
  logic signed [41:0] t;
  logic [31:0] m;
  logic [4:0]  k;
  logic [63:0] m_mul;
  logic [5:0]  bit_pos;
  logic signed [10:0] sh;
  logic [10:0] nsh;
  logic [63:0] shifted;

  // mantissa step and final shift
  assign m_mul   = 64'(m) * 64'(ROOT_TAB[k]);
  assign bit_pos = 6'd32 - 6'(k);
  assign sh      = 11'($signed(t[41:32])) + 11'sd10;
  assign nsh     = 11'(-sh);

  always_comb begin
    priority if (sh > 11'sd33) begin
      shifted = '1;
    end else if (sh >= 11'sd0) begin
      shifted = 64'(m) << sh[5:0];
    end else if (sh < -11'sd63) begin
      shifted = '0;
    end else begin
      shifted = 64'(m) >> nsh[5:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        E_IDLE: if (start) state <= E_STEP;
        E_STEP: if (k == 5'(EXP_STEPS)) state <= E_FIN;
        E_FIN: begin
          done  <= 1'b1;
          state <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      E_IDLE: if (start) begin
        t <= 42'(x) * 42'(K_EXP);
        m <= 32'd1 << 30;
        k <= 5'd1;
      end
      E_STEP: begin
        if (t[bit_pos]) m <= m_mul[61:30];
        k <= k + 5'd1;
      end
      E_FIN: res <= shifted;
      default: ;
    endcase
  end

endmodule

@@ design/nfss_log.sv @@
// Linear power to dB unit: normalise, repeated squaring, scale
`timescale 1ns / 1ps
module nfss_log (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [63:0]        v_in,
  output logic               done,
  output logic signed [15:0] res
);
  import nfss_pkg::*;

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_NORM = 5'b00010,
    L_SQ   = 5'b00100,
    L_MUL  = 5'b01000,
    L_FIN  = 5'b10000
  } log_state_t;

  log_state_t state;
  logic [63:0] v;
  logic [5:0]  z;
  logic [30:0] m;
  logic [4:0]  j;
  logic [19:0] frac;
  logic signed [45:0] prod;
  logic [61:0] sq;
  logic [31:0] s;
  logic [5:0]  p;
  logic signed [6:0] lp;
  logic signed [26:0] l;
  logic signed [45:0] rnd;
  logic signed [17:0] r;
  logic signed [15:0] r_sat;

  // squaring step
  assign sq = 62'(m) * 62'(m);
  assign s  = sq[61:30];

  // log2 in Q.20 and scaled rounding
  assign p   = 6'd63 - z;
  assign lp  = $signed(7'(p)) - 7'sd40;
  assign l   = {lp, frac};
  assign rnd = prod + 46'sd134217728;
  assign r   = rnd[45:28];

  always_comb begin
    priority if (r > 18'sd32767) begin
      r_sat = 16'sh7FFF;
    end else if (r < -18'sd32768) begin
      r_sat = 16'sh8000;
    end else begin
      r_sat = r[15:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: if (start) begin
          if (v_in == '0) done <= 1'b1;
          else state <= L_NORM;
        end
        L_NORM: if (v[63:56] != '0 && v[63]) state <= L_SQ;
        L_SQ: if (j == 5'(LOG_BITS - 1)) state <= L_MUL;
        L_MUL: state <= L_FIN;
        L_FIN: begin
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      L_IDLE: if (start) begin
        v <= v_in;
        z <= '0;
        if (v_in == '0) res <= DB_OF_ZERO;
      end
      L_NORM: begin
        priority if (v[63:56] == '0) begin
          v <= v << 8;
          z <= z + 6'd8;
        end else if (!v[63]) begin
          v <= v << 1;
          z <= z + 6'd1;
        end else begin
          m    <= v[63:33];
          j    <= '0;
          frac <= '0;
        end
      end
      L_SQ: begin
        frac <= {frac[18:0], s[31]};
        m    <= s[31] ? s[31:1] : s[30:0];
        j    <= j + 5'd1;
      end
      L_MUL: prod <= 46'(l) * 46'(K_DB);
      L_FIN: res <= r_sat;
      default: ;
    endcase
  end

endmodule

@@ design/nfss_dp.sv @@
// Datapath: item registers, bin stores, divider, conversion units and result register
`timescale 1ns / 1ps
module nfss_dp #(
  parameter int MAX_BINS  = 1024,
  parameter int SUM_WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  nfss_pkg::dp_cmd_t        cmd,
  output nfss_pkg::dp_stat_t       stat,
  input  logic [1:0]               in_func,
  input  logic signed [15:0]       in_mag_db,
  input  logic                     in_frame_end,
  input  logic                     cfg_we,
  input  logic [3:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [15:0]       out_clean_db,
  output logic                     out_estimate_done,
  output logic                     out_floor_ready,
  output logic                     out_frame_last
);
  import nfss_pkg::*;

  localparam int AW  = $clog2(MAX_BINS);
  localparam int DCW = $clog2(SUM_WIDTH);
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

  // configuration
  logic [10:0] bins_in_use;
  logic [8:0]  frames_to_average;
  logic signed [15:0] noise_margin;
  logic signed [15:0] output_floor_db;

  // item and block state
  func_t func_r;
  logic signed [15:0] x_r;
  logic fe_r;
  logic [10:0] pos;
  logic [8:0]  frames_seen;
  logic ready_flag;
  logic [AW-1:0] idx;
  logic [63:0] ps;
  logic signed [15:0] clean;
  logic done_r;

  // stores
  logic [SUM_WIDTH-1:0] power_sum [MAX_BINS];
  logic signed [15:0]   floor_level [MAX_BINS];
  logic [SUM_WIDTH-1:0] sum_q;
  logic signed [15:0]   floor_q;
  logic [AW-1:0] addr;

  // divider
  logic dbusy;
  logic div_done;
  logic [DCW-1:0] dcnt;
  logic [SUM_WIDTH-1:0] quo;
  logic [8:0] rem;
  logic [9:0] rem_sh;
  logic qbit;
  logic [8:0] rem_nx;

  // derived values
  logic [12:0] nb;
  logic [8:0]  nf;
  logic [8:0]  fnext;
  logic signed [15:0] x_clamp;
  logic signed [17:0] exp_x;
  logic exp_done;
  logic [63:0] exp_res;
  logic log_done;
  logic signed [15:0] log_res;
  logic [63:0] log_v;
  logic [64:0] sum_wide;
  logic [SUM_WIDTH-1:0] sum_new;
  logic [63:0] pdiff;
  logic [63:0] pc;

  // effective bin and frame counts
  always_comb begin
    priority if (bins_in_use == '0) nb = 13'd1;
    else if (13'(bins_in_use) > 13'(MAX_BINS)) nb = 13'(MAX_BINS);
    else nb = 13'(bins_in_use);
  end
  assign nf    = (frames_to_average == '0) ? 9'd1 : frames_to_average;
  assign fnext = frames_seen + 9'd1;

  // input level clamp
  always_comb begin
    priority if (in_mag_db < MAG_MIN) x_clamp = MAG_MIN;
    else if (in_mag_db > MAG_MAX) x_clamp = MAG_MAX;
    else x_clamp = in_mag_db;
  end

  // conversion operands
  assign exp_x    = cmd.exp_src ? (18'(floor_q) + 18'(noise_margin)) : 18'(x_r);
  assign sum_wide = 65'(exp_res) + 65'(sum_q);
  assign sum_new  = (sum_wide > 65'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_WIDTH-1:0];
  assign pdiff    = (ps > exp_res) ? ps - exp_res : '0;
  assign pc       = (pdiff < POWER_MIN) ? POWER_MIN : pdiff;
  assign log_v    = cmd.log_src ? 64'(quo) : pc;
  assign addr     = cmd.mem_idx ? idx : AW'(pos);

  nfss_exp u_exp (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.exp_start),
    .x     (exp_x),
    .done  (exp_done),
    .res   (exp_res)
  );

  nfss_log u_log (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.log_start),
    .v_in  (log_v),
    .done  (log_done),
    .res   (log_res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bins_in_use       <= 11'd1024;
      frames_to_average <= 9'd16;
      noise_margin      <= '0;
      output_floor_db   <= -16'sd30720;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BINS:   bins_in_use <= cfg_data[10:0];
        REG_FRAMES: frames_to_average <= cfg_data[8:0];
        REG_MARGIN: noise_margin <= cfg_data;
        REG_OFLOOR: output_floor_db <= cfg_data;
        default: ;
      endcase
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      frames_seen <= '0;
      ready_flag  <= 1'b0;
      idx         <= '0;
    end else begin
      if (cmd.clr_state) begin
        pos         <= '0;
        frames_seen <= '0;
        ready_flag  <= 1'b0;
      end
      if (cmd.frame_inc) frames_seen <= fnext;
      if (cmd.set_ready) ready_flag <= 1'b1;
      if (cmd.emit && (func_r == FUNC_EST || func_r == FUNC_SUB)) begin
        if (fe_r) pos <= '0;
        else if (pos != POS_MAX) pos <= pos + 11'd1;
      end
      if (cmd.idx_clr) idx <= '0;
      else if (cmd.idx_inc) idx <= idx + AW'(1);
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func_t'(in_func);
      x_r    <= x_clamp;
      fe_r   <= in_frame_end;
      clean  <= '0;
      done_r <= 1'b0;
    end
    if (cmd.set_ready) done_r <= 1'b1;
    if (cmd.ps_keep) ps <= exp_res;
    if (cmd.clean_ofl) clean <= output_floor_db;
    if (cmd.clean_log) clean <= (log_res < output_floor_db) ? output_floor_db : log_res;
  end

  // per-bin power sums
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) power_sum[addr] <= '0;
    else if (cmd.sum_wr) power_sum[addr] <= sum_new;
    sum_q <= power_sum[addr];
  end

  // per-bin noise floor
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) floor_level[addr] <= '0;
    else if (cmd.floor_wr) floor_level[addr] <= log_res;
    floor_q <= floor_level[addr];
  end

  // restoring divider, one quotient bit a cycle
  assign rem_sh = {rem, quo[SUM_WIDTH-1]};
  assign qbit   = rem_sh >= {1'b0, nf};
  assign rem_nx = qbit ? 9'(rem_sh - {1'b0, nf}) : rem_sh[8:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy    <= 1'b0;
      div_done <= 1'b0;
      dcnt     <= '0;
    end else begin
      div_done <= 1'b0;
      if (cmd.div_start) begin
        dbusy <= 1'b1;
        dcnt  <= '0;
      end else if (dbusy) begin
        dcnt <= dcnt + DCW'(1);
        if (dcnt == DCW'(SUM_WIDTH - 1)) begin
          dbusy    <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= sum_q;
      rem <= '0;
    end else if (dbusy) begin
      rem <= rem_nx;
      quo <= {quo[SUM_WIDTH-2:0], qbit};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_clean_db      <= clean;
      out_estimate_done <= done_r;
      out_floor_ready   <= ready_flag;
      out_frame_last    <= fe_r;
    end
  end

  // status
  always_comb begin
    stat.func          = func_r;
    stat.ready_flag    = ready_flag;
    stat.in_range      = 13'(pos) < nb;
    stat.idx_last_clr  = idx == AW'(MAX_BINS - 1);
    stat.idx_last_walk = 13'(idx) == nb - 13'd1;
    stat.frames_hit    = fnext >= nf;
    stat.fe            = fe_r;
    stat.exp_done      = exp_done;
    stat.log_done      = log_done;
    stat.div_done      = div_done;
    stat.out_free      = !out_valid || out_ready;
  end

  // a result is never loaded over one that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result register overwritten while full");

  // sums only accumulate for bins in use before the floor is fixed
  a_sum_wr: assert property (@(posedge clk) disable iff (rst)
    cmd.sum_wr |-> (exp_done && !ready_flag && 13'(pos) < nb))
    else $error("power sum written out of order");

  // floor written only with a fresh conversion and inside the bins in use
  a_floor_wr: assert property (@(posedge clk) disable iff (rst)
    cmd.floor_wr |-> (log_done && 13'(idx) < nb))
    else $error("floor written without a finished conversion");

endmodule

@@ design/nfss_ctrl.sv @@
// Controller state machine sequencing the datapath for each request
`timescale 1ns / 1ps
module nfss_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  nfss_pkg::dp_stat_t stat,
  output nfss_pkg::dp_cmd_t  cmd
);
  import nfss_pkg::*;

  typedef enum logic [12:0] {
    S_RST_CLR   = 13'b0000000000001,
    S_IDLE      = 13'b0000000000010,
    S_DISPATCH  = 13'b0000000000100,
    S_CLR       = 13'b0000000001000,
    S_EST_EXP   = 13'b0000000010000,
    S_EST_FRAME = 13'b0000000100000,
    S_WALK_RD   = 13'b0000001000000,
    S_WALK_ST   = 13'b0000010000000,
    S_WALK_DIV  = 13'b0000100000000,
    S_WALK_LOG  = 13'b0001000000000,
    S_SUB_EXP1  = 13'b0010000000000,
    S_SUB_EXP2  = 13'b0100000000000,
    S_EMIT      = 13'b1000000000000
  } ctrl_state_t;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic sub_log;
  logic sub_log_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_RST_CLR;
      sub_log <= 1'b0;
    end else begin
      state   <= state_next;
      sub_log <= sub_log_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    cmd          = '0;
    state_next   = state;
    sub_log_next = sub_log;
    unique case (state)
      // clearing pass after reset
      S_RST_CLR: begin
        cmd.clr_wr  = 1'b1;
        cmd.mem_idx = 1'b1;
        if (stat.idx_last_clr) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_IDLE: if (req_valid) begin
        cmd.load   = 1'b1;
        state_next = S_DISPATCH;
      end
      // pick the work for the request
      S_DISPATCH: begin
        unique case (stat.func)
          FUNC_NOP: state_next = S_EMIT;
          FUNC_CLR: begin
            cmd.clr_state = 1'b1;
            state_next    = S_CLR;
          end
          FUNC_EST: begin
            priority if (stat.ready_flag) begin
              state_next = S_EMIT;
            end else if (stat.in_range) begin
              cmd.exp_start = 1'b1;
              state_next    = S_EST_EXP;
            end else begin
              state_next = S_EST_FRAME;
            end
          end
          FUNC_SUB: begin
            if (stat.in_range) begin
              cmd.exp_start = 1'b1;
              state_next    = S_SUB_EXP1;
            end else begin
              cmd.clean_ofl = 1'b1;
              state_next    = S_EMIT;
            end
          end
          default: state_next = S_EMIT;
        endcase
      end
      // clear pass for a clear request
      S_CLR: begin
        cmd.clr_wr  = 1'b1;
        cmd.mem_idx = 1'b1;
        if (stat.idx_last_clr) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      // accumulate bin power
      S_EST_EXP: if (stat.exp_done) begin
        cmd.sum_wr = 1'b1;
        state_next = S_EST_FRAME;
      end
      S_EST_FRAME: begin
        if (stat.fe) begin
          cmd.frame_inc = 1'b1;
          state_next    = stat.frames_hit ? S_WALK_RD : S_EMIT;
        end else begin
          state_next = S_EMIT;
        end
      end
      // walk the bins in use and fix the floor
      S_WALK_RD: begin
        cmd.mem_idx = 1'b1;
        state_next  = S_WALK_ST;
      end
      S_WALK_ST: begin
        cmd.mem_idx   = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = S_WALK_DIV;
      end
      S_WALK_DIV: begin
        cmd.mem_idx = 1'b1;
        if (stat.div_done) begin
          cmd.log_start = 1'b1;
          cmd.log_src   = 1'b1;
          state_next    = S_WALK_LOG;
        end
      end
      S_WALK_LOG: begin
        cmd.mem_idx = 1'b1;
        if (stat.log_done) begin
          cmd.floor_wr = 1'b1;
          if (stat.idx_last_walk) begin
            cmd.idx_clr   = 1'b1;
            cmd.set_ready = 1'b1;
            state_next    = S_EMIT;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_WALK_RD;
          end
        end
      end
      // signal power, then floor plus margin power
      S_SUB_EXP1: if (stat.exp_done) begin
        cmd.ps_keep   = 1'b1;
        cmd.exp_start = 1'b1;
        cmd.exp_src   = 1'b1;
        state_next    = S_SUB_EXP2;
      end
      // difference back to dB
      S_SUB_EXP2: begin
        cmd.exp_src = 1'b1;
        if (sub_log) begin
          if (stat.log_done) begin
            cmd.clean_log = 1'b1;
            sub_log_next  = 1'b0;
            state_next    = S_EMIT;
          end
        end else if (stat.exp_done) begin
          cmd.log_start = 1'b1;
          sub_log_next  = 1'b1;
        end
      end
      S_EMIT: if (stat.out_free) begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ sim/noise_floor_spectral_subtract_core_test.sv @@
// Testbench of the noise-floor spectral subtraction core: fixed-point predictor and scoreboard
`timescale 1ns / 1ps

typedef struct {
  logic signed [15:0] clean;
  logic               done;
  logic               rdy;
  logic               last;
} bin_result_t;

class spectral_scoreboard;
  int unsigned        bins_cfg;
  int unsigned        frames_cfg;
  int                 margin;
  int                 ofloor;
  logic [63:0]        power_acc [1024];
  logic signed [15:0] floor_db [1024];
  int unsigned        frame_count;
  int unsigned        bin_pos;
  bit                 floor_set;
  logic [63:0]        root2 [25];
  bin_result_t        pending [$];
  int                 errors;
  int                 checked;
  int                 done_seen;

  function new();
    root2[0] = 64'h8000_0000;
    root2[1] = int_sqrt(64'd1 << 61);
    for (int k = 2; k <= 24; k++) root2[k] = int_sqrt(root2[k-1] << 30);
    bins_cfg = 1024;
    frames_cfg = 16;
    margin = 0;
    ofloor = -30720;
    clear_all();
  endfunction

  function logic [63:0] int_sqrt(logic [63:0] v_in);
    logic [63:0] v, r, b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function void clear_all();
    foreach (power_acc[i]) begin
      power_acc[i] = 0;
      floor_db[i] = 0;
    end
    frame_count = 0;
    bin_pos = 0;
    floor_set = 0;
  endfunction

  function void write_cfg(logic [3:0] idx, logic [15:0] data);
    case (idx)
      nfss_pkg::REG_BINS:   bins_cfg = data[10:0];
      nfss_pkg::REG_FRAMES: frames_cfg = data[8:0];
      nfss_pkg::REG_MARGIN: margin = int'($signed(data));
      nfss_pkg::REG_OFLOOR: ofloor = int'($signed(data));
      default: ;
    endcase
  endfunction

  // Q8.8 dB to U24.40 linear power
  function logic [63:0] db_to_power(int x);
    longint      t;
    logic [63:0] u, m;
    int          n, sh;
    logic [31:0] f;
    t = longint'(x) * 64'sd5573271;
    u = t + (64'sd1 <<< 40);
    n = int'(u >> 32) - 256;
    f = u[31:0];
    m = 64'd1 << 30;
    for (int k = 1; k <= 24; k++) if (f[32-k]) m = (m * root2[k]) >> 30;
    sh = n + 10;
    if (sh >= 0) begin
      if (sh > 33) return '1;
      return m << sh;
    end
    if (sh < -63) return 0;
    return m >> (-sh);
  endfunction

  // U24.40 linear power to Q8.8 dB
  function int power_to_db(logic [63:0] v);
    int          p;
    logic [63:0] m;
    longint      frac, l, x, r;
    if (v == 0) return -32768;
    p = 63;
    while (!v[p]) p--;
    m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
    frac = 0;
    for (int k = 0; k < 20; k++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    l = longint'(p - 40) * (64'sd1 <<< 20) + frac;
    x = l * 64'sd197283 + (64'sd1 <<< 27);
    r = x >>> 28;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return int'(r);
  endfunction

  // work out the result of one accepted request
  function void note_input(logic [1:0] f, logic [15:0] mag, logic fe);
    bin_result_t e;
    int          x, clean;
    int unsigned nb, nf, pos;
    logic [63:0] p, s, ps, pn, pc;
    x = int'($signed(mag));
    if (x < -30720) x = -30720;
    if (x > 10240) x = 10240;
    nb = (bins_cfg == 0) ? 1 : ((bins_cfg > 1024) ? 1024 : bins_cfg);
    nf = (frames_cfg == 0) ? 1 : frames_cfg;
    pos = bin_pos;
    clean = 0;
    e.done = 0;
    if (f == nfss_pkg::FUNC_CLR) begin
      clear_all();
    end else if (f == nfss_pkg::FUNC_EST || f == nfss_pkg::FUNC_SUB) begin
      if (f == nfss_pkg::FUNC_EST) begin
        if (!floor_set) begin
          if (pos < nb) begin
            p = db_to_power(x);
            s = power_acc[pos];
            power_acc[pos] = (p > ~s) ? '1 : s + p;
          end
          if (fe) begin
            frame_count = (frame_count + 1) & 9'h1FF;
            if (frame_count >= nf) begin
              for (int i = 0; i < nb; i++)
                floor_db[i] = 16'(power_to_db(power_acc[i] / nf));
              floor_set = 1;
              e.done = 1;
              done_seen++;
            end
          end
        end
      end else if (pos < nb) begin
        ps = db_to_power(x);
        pn = db_to_power(int'(floor_db[pos]) + margin);
        pc = (ps > pn) ? ps - pn : 0;
        if (pc < 110) pc = 110;
        clean = power_to_db(pc);
        if (clean < ofloor) clean = ofloor;
      end else begin
        clean = ofloor;
      end
      bin_pos = fe ? 0 : ((pos < 2047) ? pos + 1 : pos);
    end
    e.clean = 16'(clean);
    e.rdy = floor_set;
    e.last = fe;
    pending.push_back(e);
  endfunction

  task report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch on result %0d: %s got %0h expected %0h", checked, what, got, want);
    errors++;
  endtask

  task check_result(logic [15:0] clean, logic done, logic rdy, logic last);
    bin_result_t e;
    if (pending.size() == 0) begin
      $display("unexpected result: clean_db %0h with nothing outstanding", clean);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (clean !== e.clean) report("clean_db", clean, e.clean);
    if (done !== e.done) report("estimate_done", 16'(done), 16'(e.done));
    if (rdy !== e.rdy) report("floor_ready", 16'(rdy), 16'(e.rdy));
    if (last !== e.last) report("frame_last", 16'(last), 16'(e.last));
    checked++;
  endtask
endclass

module noise_floor_spectral_subtract_core_test;
  import nfss_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   burst_left = 0;
  int   requests_sent = 0;
  int   quiet_cycles = 0;
  int   stall_cnt = 0;
  int   stall_mode = 0;

  nfss_bin_if    bin_ch ();
  nfss_result_if res_ch ();
  nfss_cfg_if    cfg_ch ();

  spectral_scoreboard sb = new();

  noise_floor_spectral_subtract_core dut (
    .clk    (clk),
    .rst    (rst),
    .bin    (bin_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  // result receiver stall pattern, its mode picked at random among four
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 400 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: res_ch.ready <= 1'b1;
      1: res_ch.ready <= ($urandom_range(0, 3) != 0);
      2: res_ch.ready <= (stall_cnt % 16 >= 5);
      default: res_ch.ready <= (stall_cnt % 64 >= 40);
    endcase
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.clean_db, res_ch.estimate_done, res_ch.floor_ready,
                      res_ch.frame_last);
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if ((bin_ch.valid && bin_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles > 400000) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one bin request, sent in bursts with random gaps
  task automatic send_bin(func_t f, logic [15:0] mag, logic fe);
    if (burst_left == 0) begin
      bin_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    bin_ch.valid = 1'b1;
    bin_ch.func = f;
    bin_ch.mag_db = mag;
    bin_ch.frame_end = fe;
    do @(posedge clk); while (!bin_ch.ready);
    sb.note_input(f, mag, fe);
    requests_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // lower valid and wait until every result is back
  task automatic drain();
    bin_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_cfg(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_regs(logic [15:0] nb, logic [15:0] nf, logic [15:0] mg, logic [15:0] of);
    drain();
    write_reg(REG_BINS, nb);
    write_reg(REG_FRAMES, nf);
    write_reg(REG_MARGIN, mg);
    write_reg(REG_OFLOOR, of);
  endtask

  function automatic logic [15:0] rand_mag();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 40960)) - 30720);
  endfunction

  // one frame of bins, mostly well formed, sometimes short or long
  task automatic send_frame(func_t f, int len);
    int n;
    n = len;
    if ($urandom_range(0, 7) == 0) n = $urandom_range(1, len + 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_bin(FUNC_NOP, 16'($urandom), 1'($urandom_range(0, 1)));
      send_bin(f, rand_mag(), i == n - 1);
    end
  endtask

  task automatic run_phase();
    int nb, nf;
    logic [15:0] mg, of;
    nb = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
    nf = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
    mg = $urandom_range(0, 1) ? 16'($urandom) : 16'(int'($urandom_range(0, 3072)) - 1536);
    case ($urandom_range(0, 4))
      0, 1: of = -16'sd30720;
      2: of = 16'($urandom);
      default: of = 16'(int'($urandom_range(0, 10240)) - 8192);
    endcase
    set_regs(16'(nb), 16'(nf), mg, of);
    if ($urandom_range(0, 3) != 0) send_bin(FUNC_CLR, 16'($urandom), 1'($urandom_range(0, 1)));
    for (int i = 0; i < ((nf == 0) ? 1 : nf); i++) send_frame(FUNC_EST, (nb == 0) ? 1 : nb);
    if ($urandom_range(0, 3) == 0) send_frame(FUNC_EST, (nb == 0) ? 1 : nb);
    repeat ($urandom_range(1, 3)) send_frame(FUNC_SUB, ((nb == 0) ? 1 : nb) + $urandom_range(0, 1));
  endtask

  initial begin
    bin_ch.valid = 0;
    bin_ch.func = FUNC_EST;
    bin_ch.mag_db = 0;
    bin_ch.frame_end = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = REG_BINS;
    cfg_ch.data = 0;
    res_ch.ready = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: idle operation, subtract with an empty floor, field extremes
    set_regs(16'd4, 16'd2, 16'd0, -16'sd30720);
    send_bin(FUNC_NOP, 16'h7FFF, 1'b1);
    send_bin(FUNC_NOP, 16'h8000, 1'b0);
    send_bin(FUNC_SUB, 16'sd10240, 1'b0);
    send_bin(FUNC_SUB, -16'sd30720, 1'b0);
    send_bin(FUNC_SUB, 16'h7FFF, 1'b0);
    send_bin(FUNC_SUB, 16'h8000, 1'b1);
    // two estimate frames, the second longer than the bins in use
    for (int i = 0; i < 4; i++) send_bin(FUNC_EST, 16'(i * 2560 - 3000), i == 3);
    for (int i = 0; i < 6; i++) send_bin(FUNC_EST, 16'(i * 1000 - 2000), i == 5);
    // estimate while the floor is ready is ignored
    send_bin(FUNC_EST, 16'sd10240, 1'b1);
    // noise above signal, and bins past the end
    for (int i = 0; i < 6; i++) send_bin(FUNC_SUB, (i == 1) ? -16'sd30720 : 16'sd2560, i == 5);
    send_bin(FUNC_CLR, 16'h0, 1'b0);
    send_bin(FUNC_SUB, 16'sd0, 1'b1);

    // register extremes: margin and output floor at both ends
    set_regs(16'd2, 16'd1, 16'h7FFF, 16'h8000);
    send_bin(FUNC_EST, 16'sd10240, 1'b0);
    send_bin(FUNC_EST, -16'sd30720, 1'b1);
    send_bin(FUNC_SUB, 16'sd10240, 1'b0);
    send_bin(FUNC_SUB, 16'sd0, 1'b1);
    set_regs(16'd2, 16'd0, 16'h8000, 16'h7FFF);
    send_bin(FUNC_SUB, 16'sd10240, 1'b0);
    send_bin(FUNC_SUB, 16'sd0, 1'b1);

    // bins above the store size, one short frame, full walk
    set_regs(16'd2047, 16'd1, 16'd0, -16'sd30720);
    send_bin(FUNC_CLR, 16'h0, 1'b0);
    for (int i = 0; i < 3; i++) send_bin(FUNC_EST, rand_mag(), i == 2);
    for (int i = 0; i < 3; i++) send_bin(FUNC_SUB, rand_mag(), i == 2);

    // a frame count of 256 with a single bin
    set_regs(16'd1, 16'd256, 16'd0, -16'sd30720);
    send_bin(FUNC_CLR, 16'h0, 1'b1);
    for (int i = 0; i < 257; i++) send_bin(FUNC_EST, rand_mag(), 1'b1);
    send_bin(FUNC_SUB, rand_mag(), 1'b1);

    // random phases
    while (requests_sent < 1000) run_phase();
    drain();
    repeat (200) @(negedge clk);

    $display("sent %0d bin requests, checked %0d results, %0d floor estimates completed",
             requests_sent, sb.checked, sb.done_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
